// ----- hw/rtl/npc_pkg.sv -----
`default_nettype none

package npc_pkg;

  localparam int DIST_W = 18;
  localparam logic [DIST_W-1:0] DIST_MAX = 18'd195075;
  localparam logic [DIST_W-1:0] DIST_INIT = '1;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef struct packed {
    logic vld;
    logic last;
  } tag_t;

endpackage

`default_nettype wire

// ----- hw/rtl/npc_palette_mem.sv -----
`default_nettype none

module npc_palette_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [23:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [23:0]   rdata_r
);

  logic [23:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/npc_dist_unit.sv -----
`default_nettype none

module npc_dist_unit #(
  parameter int IDX_W = 6
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [7:0]                 px_red,
  input  wire logic [7:0]                 px_green,
  input  wire logic [7:0]                 px_blue,
  input  wire logic [23:0]                color,
  input  wire logic [IDX_W-1:0]           idx,
  input  wire npc_pkg::tag_t              tag,
  output npc_pkg::tag_t                   tag_b_r,
  output logic      [IDX_W-1:0]           idx_b_r,
  output logic      [23:0]                color_b_r,
  output logic      [npc_pkg::DIST_W-1:0] dist_b_r
);

  npc_pkg::tag_t    tag_a_r;
  logic [IDX_W-1:0] idx_a_r;
  logic [23:0]      color_a_r;
  logic [15:0]      sq_r_r, sq_g_r, sq_b_r;
  logic [7:0]       d_r, d_g, d_b;

  assign d_r = (px_red   > color[23:16]) ? px_red   - color[23:16] : color[23:16] - px_red;
  assign d_g = (px_green > color[15:8])  ? px_green - color[15:8]  : color[15:8]  - px_green;
  assign d_b = (px_blue  > color[7:0])   ? px_blue  - color[7:0]   : color[7:0]   - px_blue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
    end else begin
      tag_a_r <= tag;
      tag_b_r <= tag_a_r;
    end
    idx_a_r   <= idx;
    color_a_r <= color;
    sq_r_r    <= 16'(d_r) * 16'(d_r);
    sq_g_r    <= 16'(d_g) * 16'(d_g);
    sq_b_r    <= 16'(d_b) * 16'(d_b);
    idx_b_r   <= idx_a_r;
    color_b_r <= color_a_r;
    dist_b_r  <= npc_pkg::DIST_W'(sq_r_r) + npc_pkg::DIST_W'(sq_g_r)
               + npc_pkg::DIST_W'(sq_b_r);
  end

endmodule

`default_nettype wire

// ----- hw/rtl/nearest_palette_color.sv -----
// Load words produce no output word.
// A pixel word searches entries 0 to N-1 one per cycle, where N is palette_size
// clamped to 1..PALETTE_DEPTH.
// One pixel is in flight at a time; no word is accepted until its result is registered.
// Synchronous active-low reset sets palette_size to 64 and empties the pipeline;
// palette contents are not cleared and must be loaded before use.
`default_nettype none

module nearest_palette_color #(
  parameter int PALETTE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // entry_index[5:0], red[13:6], green[21:14], blue[29:22]
  input  wire logic [31:0] in_tdata,
  // kind[0]
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], match_index[29:24]
  output logic      [31:0] out_tdata,
  input  wire logic        cfg_tvalid,
  output logic             cfg_tready,
  // palette_size[6:0]
  input  wire logic [7:0]  cfg_tdata
);

  localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [6:0]       size_r;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic [IDX_W-1:0] last_r;
  logic [7:0]       px_red_r, px_green_r, px_blue_r;
  logic             in_acc, is_pixel, is_load;
  logic [5:0]       in_idx;
  logic [8:0]       lim;

  npc_pkg::tag_t    tag_s, tag_m_r, tag_b;
  logic [IDX_W-1:0] idx_m_r, idx_b;
  logic [23:0]      rdata, color_b;
  logic [npc_pkg::DIST_W-1:0] dist_b;

  logic [npc_pkg::DIST_W-1:0] best_dist_r;
  logic [IDX_W-1:0]           best_idx_r;
  logic [23:0]                best_color_r;

  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_load;

  assign cfg_tready = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign is_pixel   = in_acc && (in_tuser[0] == npc_pkg::KIND_PIXEL);
  assign in_idx     = in_tdata[5:0];
  assign is_load    = in_acc && (in_tuser[0] == npc_pkg::KIND_LOAD)
                      && ({3'b000, in_idx} < DEPTH9);

  always_comb begin
    lim = {2'b00, size_r};
    if (lim == 9'd0) begin
      lim = 9'd1;
    end
    if (lim > DEPTH9) begin
      lim = DEPTH9;
    end
  end

  npc_palette_mem #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .we      (is_load),
    .waddr   (IDX_W'(in_idx)),
    .wdata   ({in_tdata[13:6], in_tdata[21:14], in_tdata[29:22]}),
    .raddr   (addr_r),
    .rdata_r (rdata)
  );

  assign tag_s.vld  = (state_r == ST_SEARCH);
  assign tag_s.last = (addr_r == last_r);

  npc_dist_unit #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .px_red    (px_red_r),
    .px_green  (px_green_r),
    .px_blue   (px_blue_r),
    .color     (rdata),
    .idx       (idx_m_r),
    .tag       (tag_m_r),
    .tag_b_r   (tag_b),
    .idx_b_r   (idx_b),
    .color_b_r (color_b),
    .dist_b_r  (dist_b)
  );

  assign out_load = (state_r == ST_RESULT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    unique case (state_r)
      ST_IDLE: begin
        addr_nxt = '0;
        if (is_pixel) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        addr_nxt = addr_r + 1'b1;
        if (tag_s.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (tag_b.vld && tag_b.last) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= 7'd64;
      tag_m_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tag_m_r <= tag_s;
      if (cfg_tvalid && cfg_tready) begin
        size_r <= cfg_tdata[6:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    addr_r  <= addr_nxt;
    idx_m_r <= addr_r;
    if (is_pixel) begin
      px_red_r    <= in_tdata[13:6];
      px_green_r  <= in_tdata[21:14];
      px_blue_r   <= in_tdata[29:22];
      last_r      <= IDX_W'(lim - 9'd1);
      best_dist_r <= npc_pkg::DIST_INIT;
    end else if (tag_b.vld && (dist_b < best_dist_r)) begin
      best_dist_r  <= dist_b;
      best_idx_r   <= idx_b;
      best_color_r <= color_b;
    end
    if (out_load) begin
      out_data_r <= {2'b00, 6'(best_idx_r), best_color_r[7:0], best_color_r[15:8],
                     best_color_r[23:16]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == ST_RESULT)
    else $error("output word raised without a finished search");

  a_compare_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tag_b.vld |-> (state_r == ST_SEARCH || state_r == ST_DRAIN))
    else $error("distance result outside a search");

  a_best_found: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RESULT |-> best_dist_r <= npc_pkg::DIST_MAX)
    else $error("search finished without a candidate");

endmodule

`default_nettype wire

// ----- test/nearest_palette_color_test.sv -----
`timescale 1ns / 1ps

module nearest_palette_color_test;

  localparam int PALETTE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int IDLE_PERCENT = 32;

  typedef struct packed {
    bit [7:0] blue;
    bit [7:0] green;
    bit [7:0] red;
  } rgb_t;

  typedef struct packed {
    rgb_t     color;
    bit [5:0] index;
  } match_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_tvalid;
  logic        cfg_tready;
  logic [7:0]  cfg_tdata;

  rgb_t        palette_copy [PALETTE_DEPTH];
  bit   [6:0]  size_setting = 7'd64;
  match_t      expected_matches [$];
  bit          no_idle = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned load_count = 0;
  int unsigned pixel_count = 0;
  int unsigned checked_count = 0;
  int unsigned setting_count = 0;
  int unsigned cycle_count = 0;

  nearest_palette_color #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_tvalid(cfg_tvalid),
    .cfg_tready(cfg_tready),
    .cfg_tdata (cfg_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               expected_matches.size());
      $display("** nearest_palette_color: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
  end

  function automatic int unsigned active_entries();
    if (size_setting == 7'd0) begin
      return 1;
    end
    if (size_setting > PALETTE_DEPTH) begin
      return PALETTE_DEPTH;
    end
    return size_setting;
  endfunction

  function automatic bit [npc_pkg::DIST_W-1:0] channel_dist(bit [7:0] a, bit [7:0] b);
    bit [7:0] d;
    d = (a > b) ? a - b : b - a;
    return npc_pkg::DIST_W'(d) * npc_pkg::DIST_W'(d);
  endfunction

  function automatic match_t nearest_entry(rgb_t pixel);
    bit [npc_pkg::DIST_W-1:0] best_dist;
    bit [npc_pkg::DIST_W-1:0] cand_dist;
    int unsigned              best;
    match_t                   found;
    best_dist = npc_pkg::DIST_INIT;
    best = 0;
    for (int i = 0; i < active_entries(); i++) begin
      cand_dist = channel_dist(pixel.red, palette_copy[i].red)
                + channel_dist(pixel.green, palette_copy[i].green)
                + channel_dist(pixel.blue, palette_copy[i].blue);
      if (cand_dist < best_dist) begin
        best_dist = cand_dist;
        best = i;
      end
    end
    found.color = palette_copy[best];
    found.index = best[5:0];
    return found;
  endfunction

  function automatic rgb_t random_color();
    return rgb_t'(24'($urandom));
  endfunction

  function automatic bit [7:0] nudge(bit [7:0] c);
    int v;
    v = int'(c) + $urandom_range(8) - 4;
    if (v < 0) begin
      v = 0;
    end
    if (v > 255) begin
      v = 255;
    end
    return v[7:0];
  endfunction

  task automatic note_mismatch(string what, match_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("Mismatch (%s) at cycle %0d: want %02h%02h%02h/%0d, got %02h%02h%02h/%0d",
               what, cycle_count, want.color.red, want.color.green, want.color.blue,
               want.index, out_tdata[7:0], out_tdata[15:8], out_tdata[23:16],
               out_tdata[29:24]);
    end
  endtask

  always @(posedge clk) begin : check_results
    match_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (expected_matches.size() == 0) begin
        want = '0;
        note_mismatch("unexpected word", want);
      end else begin
        want = expected_matches.pop_front();
        checked_count++;
        if (out_tdata[7:0] !== want.color.red || out_tdata[15:8] !== want.color.green ||
            out_tdata[23:16] !== want.color.blue || out_tdata[29:24] !== want.index) begin
          note_mismatch("wrong field", want);
        end
      end
    end
  end

  task automatic send_word(logic kind, bit [5:0] entry, rgb_t color);
    if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PERCENT);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {2'b00, color.blue, color.green, color.red, entry};
    do @(posedge clk); while (in_tready !== 1'b1);
    if (kind == npc_pkg::KIND_LOAD) begin
      palette_copy[entry] = color;
      load_count++;
    end else begin
      expected_matches.push_back(nearest_entry(color));
      pixel_count++;
    end
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (expected_matches.size() != 0) begin
      @(posedge clk);
    end
    repeat (PALETTE_DEPTH + 10) @(posedge clk);
  endtask

  task automatic write_size(bit [6:0] size);
    wait_for_drain();
    cfg_tvalid <= 1'b1;
    cfg_tdata <= {1'b0, size};
    do @(posedge clk); while (cfg_tready !== 1'b1);
    cfg_tvalid <= 1'b0;
    size_setting = size;
    setting_count++;
  endtask

  task automatic test_directed_cases();
    write_size(7'd4);
    send_word(npc_pkg::KIND_LOAD, 6'd0, 24'h000000);
    send_word(npc_pkg::KIND_LOAD, 6'd1, 24'hffffff);
    send_word(npc_pkg::KIND_LOAD, 6'd2, 24'h000000);
    send_word(npc_pkg::KIND_LOAD, 6'd3, 24'h808080);
    send_word(npc_pkg::KIND_PIXEL, 6'd0, 24'h000000);
    send_word(npc_pkg::KIND_PIXEL, 6'd63, 24'hffffff);
    send_word(npc_pkg::KIND_PIXEL, 6'd21, 24'h7f7f7f);
    // Equally far from entries 0, 2 and 3, so the lowest index must win.
    send_word(npc_pkg::KIND_PIXEL, 6'd42, 24'h404040);
    send_word(npc_pkg::KIND_PIXEL, 6'd5, 24'h00ff80);
    send_word(npc_pkg::KIND_LOAD, 6'd3, 24'hff0000);
    send_word(npc_pkg::KIND_PIXEL, 6'd3, 24'h0000f0);
    write_size(7'd0);
    send_word(npc_pkg::KIND_PIXEL, 6'd1, 24'hffffff);
    write_size(7'd1);
    send_word(npc_pkg::KIND_PIXEL, 6'd2, 24'hff8000);
  endtask

  task automatic send_random_word();
    rgb_t        color;
    int unsigned pick;
    bit [5:0]    entry;
    pick = $urandom_range(99);
    if (pick < 20) begin
      entry = 6'($urandom_range(PALETTE_DEPTH - 1));
      color = ($urandom_range(3) == 0) ? palette_copy[$urandom_range(PALETTE_DEPTH - 1)]
                                       : random_color();
      send_word(npc_pkg::KIND_LOAD, entry, color);
    end else begin
      entry = 6'($urandom_range(active_entries() - 1));
      if (pick < 35) begin
        color = palette_copy[entry];
      end else if (pick < 70) begin
        color.red = nudge(palette_copy[entry].red);
        color.green = nudge(palette_copy[entry].green);
        color.blue = nudge(palette_copy[entry].blue);
      end else begin
        color = random_color();
      end
      send_word(npc_pkg::KIND_PIXEL, 6'($urandom), color);
    end
  endtask

  task automatic test_random_pixels();
    bit [6:0] sizes [12] = '{7'd64, 7'd127, 7'd65, 7'd1, 7'd0, 7'd2,
                             7'd8, 7'd16, 7'd33, 7'd63, 7'd5, 7'd64};
    for (int e = 0; e < PALETTE_DEPTH; e++) begin
      send_word(npc_pkg::KIND_LOAD, e[5:0], random_color());
    end
    for (int p = 0; p < 12; p++) begin
      write_size(p == 11 ? 7'($urandom_range(1, PALETTE_DEPTH)) : sizes[p]);
      no_idle = (p == 8);
      repeat (60) send_random_word();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_tvalid <= 1'b0;
    cfg_tdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_pixels();
    wait_for_drain();
    $display("Sent %0d palette loads and %0d pixels over %0d size settings.",
             load_count, pixel_count, setting_count);
    $display("Checked %0d result words, %0d mismatches.", checked_count, mismatch_count);
    if (mismatch_count == 0 && expected_matches.size() == 0) begin
      $display("** nearest_palette_color: PASSED **");
    end else begin
      $display("** nearest_palette_color: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/npc_pkg.sv
hw/rtl/npc_palette_mem.sv
hw/rtl/npc_dist_unit.sv
hw/rtl/nearest_palette_color.sv
test/nearest_palette_color_test.sv
